/* sv/psg_pkg.sv */
package psg_pkg;

    // white noise feedback pattern register
    localparam int TAPS_W = 15;
    localparam logic [TAPS_W-1:0] TAPS_RESET = 15'h6000;

    // configuration port
    localparam int PADDR_W = 1;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_TAPS = 1'b0;

    // chip register numbers and fields
    localparam logic [2:0] REG_NOISE_CTRL = 3'd6;
    localparam logic [1:0] NOISE_MODE_TONE2 = 2'd3;
    localparam int NOISE_CTRL_W = 3;
    localparam int ATTEN_W = 4;
    localparam int AMP_W = 16;

    // noise clock generator: period 16 << mode, 128 wraps to zero
    localparam int NOISE_CNT_W = 7;
    localparam logic [NOISE_CNT_W-1:0] NOISE_BASE_PERIOD = 7'd16;

    // 2 dB per step attenuation table, last step is silent
    function automatic logic [AMP_W-1:0] vol_amp(input logic [ATTEN_W-1:0] atten);
        logic [AMP_W-1:0] amp;
        case (atten)
            4'd0:    amp = 16'd32768;
            4'd1:    amp = 16'd26029;
            4'd2:    amp = 16'd20675;
            4'd3:    amp = 16'd16423;
            4'd4:    amp = 16'd13045;
            4'd5:    amp = 16'd10362;
            4'd6:    amp = 16'd8231;
            4'd7:    amp = 16'd6538;
            4'd8:    amp = 16'd5193;
            4'd9:    amp = 16'd4125;
            4'd10:   amp = 16'd3277;
            4'd11:   amp = 16'd2603;
            4'd12:   amp = 16'd2068;
            4'd13:   amp = 16'd1642;
            4'd14:   amp = 16'd1305;
            default: amp = 16'd0;
        endcase
        return amp;
    endfunction

endpackage

/* sv/psg_in_if.sv */
interface psg_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] write_data;

    modport source (output valid, output func, output write_data, input ready);
    modport sink (input valid, input func, input write_data, output ready);
endinterface

/* sv/psg_out_if.sv */
interface psg_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] amp_tone0;
    logic [15:0] amp_tone1;
    logic [15:0] amp_tone2;
    logic [15:0] amp_noise;

    modport source (output valid, output amp_tone0, output amp_tone1, output amp_tone2,
                    output amp_noise, input ready);
    modport sink (input valid, input amp_tone0, input amp_tone1, input amp_tone2,
                  input amp_noise, output ready);
endinterface

/* sv/psg_tone_noise_generator_top.sv */
// Four-channel sound generator: three square-wave tone channels and one noise
// channel. Each input transfer is a bus byte write (func 0) or one tick of the
// divided generator clock (func 1); only ticks produce an output transfer, which
// carries the four channel amplitudes after that tick's toggles and shifts.
// The block takes one input transfer per cycle unless a tick finds a result still
// waiting in the output register. An item sits in an input register while the
// register file, the four down counters and the shift register update, and a
// tick's amplitudes then land in the output register, where its result is valid.
// The output register stalls only ticks; writes pass through while a result waits.
// The white noise feedback pattern sits at APB byte address 0 and resets to 0x6000.
// LFSR_WIDTH sets the noise shift register length, TONE_PERIOD_BITS the tone period
// width (a period of zero counts as the full range).
module psg_tone_noise_generator_top #(
    parameter int LFSR_WIDTH       = 15,
    parameter int TONE_PERIOD_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    psg_in_if.sink                         i_in,
    psg_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [psg_pkg::PADDR_W-1:0]    paddr,
    input  logic [psg_pkg::PDATA_W-1:0]    pwdata,
    output logic [psg_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import psg_pkg::*;

    logic                                r_in_valid;
    logic                                r_in_func;
    logic [7:0]                          r_in_data;
    logic                                r_out_valid;
    logic [AMP_W-1:0]                    r_amp_tone0;
    logic [AMP_W-1:0]                    r_amp_tone1;
    logic [AMP_W-1:0]                    r_amp_tone2;
    logic [AMP_W-1:0]                    r_amp_noise;
    logic [TAPS_W-1:0]                   r_taps;

    logic                                advance;
    logic                                tick;
    logic                                wr;
    logic [2:0][TONE_PERIOD_BITS-1:0]    period;
    logic [3:0][ATTEN_W-1:0]             atten;
    logic [NOISE_CTRL_W-1:0]             noise_ctrl;
    logic                                noise_reload;
    logic [2:0]                          tone_sq_next;
    logic [2:0]                          tone_rose;
    logic                                noise_clk_sq_next;
    logic                                noise_clk_rose;
    logic                                noise_shift;
    logic                                lfsr_bit0_next;
    logic [NOISE_CNT_W-1:0]              noise_period;

    // input stage moves on unless a tick finds the result register full and not being taken
    assign advance    = r_in_valid && (!r_in_func || !r_out_valid || o_out.ready);
    assign tick       = advance && r_in_func;
    assign wr         = advance && !r_in_func;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_func <= i_in.func;
            r_in_data <= i_in.write_data;
        end
    end

    // chip register file
    psg_regs #(
        .TONE_PERIOD_BITS (TONE_PERIOD_BITS)
    ) u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_data         (r_in_data),
        .o_period       (period),
        .o_atten        (atten),
        .o_noise_ctrl   (noise_ctrl),
        .o_noise_reload (noise_reload)
    );

    // three tone generators
    for (genvar g = 0; g < 3; g++) begin : g_tone
        psg_gen #(
            .CNT_W (TONE_PERIOD_BITS)
        ) u_gen (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_step        (tick),
            .i_period      (period[g]),
            .o_square_next (tone_sq_next[g]),
            .o_rose        (tone_rose[g])
        );
    end

    // noise clock generator, the longest period wraps to zero
    assign noise_period = NOISE_BASE_PERIOD << noise_ctrl[1:0];

    psg_gen #(
        .CNT_W (NOISE_CNT_W)
    ) u_noise_clk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (tick),
        .i_period      (noise_period),
        .o_square_next (noise_clk_sq_next),
        .o_rose        (noise_clk_rose)
    );

    // noise shifts on tone 2 or on its own clock, never both
    assign noise_shift = (noise_ctrl[1:0] == NOISE_MODE_TONE2) ? tone_rose[2] : noise_clk_rose;

    psg_noise #(
        .LFSR_WIDTH (LFSR_WIDTH)
    ) u_noise (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_reload    (noise_reload),
        .i_shift     (noise_shift),
        .i_white     (noise_ctrl[2]),
        .i_taps      (r_taps),
        .o_bit0_next (lfsr_bit0_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_amp_tone0 <= tone_sq_next[0] ? vol_amp(atten[0]) : '0;
            r_amp_tone1 <= tone_sq_next[1] ? vol_amp(atten[1]) : '0;
            r_amp_tone2 <= tone_sq_next[2] ? vol_amp(atten[2]) : '0;
            r_amp_noise <= lfsr_bit0_next ? '0 : vol_amp(atten[3]);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.amp_tone0 = r_amp_tone0;
    assign o_out.amp_tone1 = r_amp_tone1;
    assign o_out.amp_tone2 = r_amp_tone2;
    assign o_out.amp_noise = r_amp_noise;

    // configuration register; the noise clock square itself is not observed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= TAPS_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_TAPS)) begin
            r_taps <= pwdata[TAPS_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_TAPS) ? PDATA_W'({noise_clk_sq_next & 1'b0, r_taps}) : '0;
    assign pready = 1'b1;

endmodule

/* sv/psg_regs.sv */
module psg_regs #(
    parameter int TONE_PERIOD_BITS = 10
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_wr,
    input  logic [7:0]                                    i_data,
    output logic [2:0][TONE_PERIOD_BITS-1:0]              o_period,
    output logic [3:0][psg_pkg::ATTEN_W-1:0]              o_atten,
    output logic [psg_pkg::NOISE_CTRL_W-1:0]              o_noise_ctrl,
    output logic                                          o_noise_reload
);
    import psg_pkg::*;

    logic [2:0]                             r_latched;
    logic [2:0][TONE_PERIOD_BITS-1:0]       r_period;
    logic [3:0][ATTEN_W-1:0]                r_atten;
    logic [NOISE_CTRL_W-1:0]                r_noise_ctrl;

    logic                                   latch;
    logic [2:0]                             reg_sel;
    logic [1:0]                             idx;
    logic [TONE_PERIOD_BITS-1:0]            period_low;
    logic [TONE_PERIOD_BITS-1:0]            period_high;

    // a latch byte selects the register in the same write
    assign latch   = i_data[7];
    assign reg_sel = latch ? i_data[6:4] : r_latched;
    assign idx     = reg_sel[2:1];

    // low nibble update keeps the upper bits, data update keeps the low nibble
    always_comb begin
        period_low  = r_period[idx];
        period_low[3:0] = i_data[3:0];
        period_high = (TONE_PERIOD_BITS'(i_data[5:0]) << 4)
                    | TONE_PERIOD_BITS'(r_period[idx][3:0]);
    end

    // register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched    <= '0;
            r_period     <= '0;
            r_atten      <= '1;
            r_noise_ctrl <= '0;
        end else if (i_wr) begin
            if (latch) begin
                r_latched <= i_data[6:4];
            end
            if (reg_sel == REG_NOISE_CTRL) begin
                r_noise_ctrl <= i_data[NOISE_CTRL_W-1:0];
            end else if (reg_sel[0]) begin
                r_atten[idx] <= i_data[ATTEN_W-1:0];
            end else if (latch) begin
                r_period[idx] <= period_low;
            end else begin
                r_period[idx] <= period_high;
            end
        end
    end

    assign o_period       = r_period;
    assign o_atten        = r_atten;
    assign o_noise_ctrl   = r_noise_ctrl;
    assign o_noise_reload = i_wr && (reg_sel == REG_NOISE_CTRL);

endmodule

/* sv/psg_gen.sv */
module psg_gen #(
    parameter int CNT_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [CNT_W-1:0] i_period,
    output logic             o_square_next,
    output logic             o_rose
);
    logic [CNT_W-1:0] r_cnt;
    logic             r_square;
    logic             expire;

    // a zero period wraps to the full count through the decrement
    assign expire = i_step && (r_cnt == '0);

    // down counter with reload and square output toggle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_square <= 1'b0;
        end else if (i_step) begin
            if (expire) begin
                r_cnt    <= i_period - 1'b1;
                r_square <= ~r_square;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_square_next = expire ? ~r_square : r_square;
    assign o_rose        = expire && !r_square;

endmodule

/* sv/psg_noise.sv */
module psg_noise #(
    parameter int LFSR_WIDTH = 15
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_reload,
    input  logic                        i_shift,
    input  logic                        i_white,
    input  logic [psg_pkg::TAPS_W-1:0]  i_taps,
    output logic                        o_bit0_next
);
    import psg_pkg::*;

    localparam logic [LFSR_WIDTH-1:0] LfsrTop = LFSR_WIDTH'(1) << (LFSR_WIDTH - 1);

    logic [LFSR_WIDTH-1:0] r_lfsr;
    logic [LFSR_WIDTH-1:0] n_lfsr;
    logic [LFSR_WIDTH-1:0] taps;

    // periodic noise feeds back through the top bit only
    assign taps = i_white ? LFSR_WIDTH'(i_taps) : LfsrTop;

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_reload) begin
            n_lfsr = LfsrTop;
        end else if (i_shift) begin
            n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? taps : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LfsrTop;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

    assign o_bit0_next = n_lfsr[0];

endmodule

/* tb/psg_tone_noise_generator_top_tb.sv */
module psg_tone_noise_generator_top_tb;
    import psg_pkg::*;

    localparam int LFSR_W = 15;
    localparam int PERIOD_W = 10;
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
    localparam logic [LFSR_W-1:0] LFSR_TOP = {1'b1, {(LFSR_W-1){1'b0}}};
    localparam int N_DIRECTED = 25;
    localparam int N_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 238;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [AMP_W-1:0] amp_tone0;
        logic [AMP_W-1:0] amp_tone1;
        logic [AMP_W-1:0] amp_tone2;
        logic [AMP_W-1:0] amp_noise;
    } amp_set_t;

    typedef struct {
        logic       func;
        logic [7:0] data;
        bit         has_amps;
        amp_set_t   amps;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic pready;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;

    psg_in_if in_bus();
    psg_out_if amp_bus();

    // shared run state
    amp_set_t pending_amps[$];
    int fail_count = 0;
    int checked_count = 0;
    int tick_count = 0;
    int write_count = 0;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;
    bit hold_off_req = 1'b0;

    // sound generator state as the testbench sees it
    logic [TAPS_W-1:0]       model_taps;
    logic [PERIOD_W-1:0]     tone_period [3];
    logic [ATTEN_W-1:0]      atten [4];
    logic [NOISE_CTRL_W-1:0] noise_ctrl;
    logic [2:0]              reg_sel;
    int unsigned             gen_count [4];
    bit                      gen_out [4];
    logic [LFSR_W-1:0]       lfsr;

    // 2 dB steps, fully attenuated at the top
    logic [AMP_W-1:0] atten_level [16] = '{
        16'd32768, 16'd26029, 16'd20675, 16'd16423, 16'd13045, 16'd10362, 16'd8231,
        16'd6538, 16'd5193, 16'd4125, 16'd3277, 16'd2603, 16'd2068, 16'd1642,
        16'd1305, 16'd0
    };

    // directed items: amplitudes typed in only for the reset tick and full volume
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{FUNC_TICK,  8'h00, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
        '{FUNC_WRITE, 8'h90, 1'b0, '0},
        '{FUNC_WRITE, 8'hB0, 1'b0, '0},
        '{FUNC_WRITE, 8'hD0, 1'b0, '0},
        '{FUNC_WRITE, 8'hF0, 1'b0, '0},
        '{FUNC_TICK,  8'hFF, 1'b1, '{16'd32768, 16'd32768, 16'd32768, 16'd32768}},
        '{FUNC_WRITE, 8'h81, 1'b0, '0},
        '{FUNC_WRITE, 8'h00, 1'b0, '0},
        '{FUNC_TICK,  8'h00, 1'b0, '0},
        '{FUNC_TICK,  8'h00, 1'b0, '0},
        '{FUNC_WRITE, 8'hAF, 1'b0, '0},
        '{FUNC_WRITE, 8'h3F, 1'b0, '0},
        '{FUNC_TICK,  8'h00, 1'b0, '0},
        '{FUNC_WRITE, 8'hC2, 1'b0, '0},
        '{FUNC_WRITE, 8'h40, 1'b0, '0},
        '{FUNC_WRITE, 8'hE3, 1'b0, '0},
        '{FUNC_TICK,  8'h00, 1'b0, '0},
        '{FUNC_TICK,  8'h00, 1'b0, '0},
        '{FUNC_TICK,  8'h00, 1'b0, '0},
        '{FUNC_WRITE, 8'h07, 1'b0, '0},
        '{FUNC_TICK,  8'h00, 1'b0, '0},
        '{FUNC_WRITE, 8'h9E, 1'b0, '0},
        '{FUNC_WRITE, 8'h0F, 1'b0, '0},
        '{FUNC_WRITE, 8'hE4, 1'b0, '0},
        '{FUNC_TICK,  8'h00, 1'b0, '0}
    };

    psg_tone_noise_generator_top #(
        .LFSR_WIDTH       (LFSR_W),
        .TONE_PERIOD_BITS (PERIOD_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (amp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // power-on state of the generator
    function automatic void sound_reset();
        int i;
        model_taps = TAPS_RESET;
        for (i = 0; i < 3; i++) tone_period[i] = '0;
        for (i = 0; i < 4; i++) begin
            atten[i] = '1;
            gen_count[i] = 0;
            gen_out[i] = 1'b0;
        end
        noise_ctrl = '0;
        reg_sel = '0;
        lfsr = LFSR_TOP;
    endfunction

    // one noise step: white uses the tap register, periodic only the top bit
    function automatic void shift_noise_lfsr();
        logic [LFSR_W-1:0] taps;
        taps = noise_ctrl[2] ? model_taps[LFSR_W-1:0] : LFSR_TOP;
        lfsr = (lfsr >> 1) ^ (lfsr[0] ? taps : '0);
    endfunction

    // count one generator down, return 1 on a rising output
    function automatic bit count_generator(input int g, input int unsigned period);
        bit rose;
        rose = 1'b0;
        if (gen_count[g] == 0) begin
            gen_out[g] = ~gen_out[g];
            gen_count[g] = period;
            rose = gen_out[g];
        end
        gen_count[g] = gen_count[g] - 1;
        return rose;
    endfunction

    // byte written on the chip bus
    function automatic void apply_bus_write(input logic [7:0] v);
        if (v[7]) reg_sel = v[6:4];
        if (reg_sel == REG_NOISE_CTRL) begin
            noise_ctrl = v[NOISE_CTRL_W-1:0];
            lfsr = LFSR_TOP;
        end else if (reg_sel[0]) begin
            atten[reg_sel[2:1]] = v[ATTEN_W-1:0];
        end else if (v[7]) begin
            tone_period[reg_sel[2:1]][3:0] = v[3:0];
        end else begin
            tone_period[reg_sel[2:1]][PERIOD_W-1:4] = v[PERIOD_W-5:0];
        end
    endfunction

    // one generator clock tick, amplitudes seen after the toggles and shifts
    function automatic amp_set_t tick_amplitudes();
        amp_set_t a;
        int unsigned p;
        bit rose;
        int i;
        for (i = 0; i < 3; i++) begin
            p = tone_period[i];
            if (p == 0) p = 1 << PERIOD_W;
            rose = count_generator(i, p);
            if (i == 2 && rose && noise_ctrl[1:0] == NOISE_MODE_TONE2) shift_noise_lfsr();
        end
        rose = count_generator(3, int'(NOISE_BASE_PERIOD) << noise_ctrl[1:0]);
        if (rose && noise_ctrl[1:0] != NOISE_MODE_TONE2) shift_noise_lfsr();
        a.amp_tone0 = gen_out[0] ? atten_level[atten[0]] : '0;
        a.amp_tone1 = gen_out[1] ? atten_level[atten[1]] : '0;
        a.amp_tone2 = gen_out[2] ? atten_level[atten[2]] : '0;
        a.amp_noise = lfsr[0] ? '0 : atten_level[atten[3]];
        return a;
    endfunction

    // mostly latch bytes and short period data, some raw bytes
    function automatic logic [7:0] pick_write_byte();
        logic [7:0] b;
        int sel;
        b = 8'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            b[7] = 1'b1;
            // keep noise control reloads from resetting the shift register too often
            if (b[6:4] == REG_NOISE_CTRL && $urandom_range(0, 3) != 0) b[4] = 1'b1;
        end else if (sel < 8) begin
            b[7] = 1'b0;
            if ($urandom_range(0, 3) != 0) b[6:2] = '0;
        end
        return b;
    endfunction

    function automatic void check_field(input string field, input logic [AMP_W-1:0] want,
                                        input logic [AMP_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // one input transfer after a random gap, then predict it
    task automatic send_item(input logic f, input logic [7:0] d, input bit has_amps,
                             input amp_set_t typed_amps);
        int gap;
        amp_set_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.func <= f;
        in_bus.write_data <= d;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        if (f == FUNC_TICK) begin
            predicted = tick_amplitudes();
            pending_amps.push_back(has_amps ? typed_amps : predicted);
            tick_count++;
        end else begin
            apply_bus_write(d);
            write_count++;
        end
    endtask

    // stop sending and wait for every outstanding tick result
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (pending_amps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // optional tap register write, always followed by a read back
    task automatic taps_access(input bit do_write, input logic [TAPS_W-1:0] value);
        if (do_write) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= ADDR_TAPS;
            pwdata <= {{(PDATA_W-TAPS_W){1'b0}}, value};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            model_taps = value;
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_TAPS;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[TAPS_W-1:0] !== model_taps) begin
            $error("white_noise_taps mismatch: expected %0h, actual %0h",
                   model_taps, prdata[TAPS_W-1:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : amp_sink
        int stall;
        amp_set_t want;
        amp_bus.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (hold_off_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall > 0) begin
                amp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            amp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (amp_bus.valid !== 1'b1);
            if (pending_amps.size() == 0) begin
                $error("amplitude transfer with no tick waiting");
                fail_count++;
            end else begin
                want = pending_amps.pop_front();
                check_field("amp_tone0", want.amp_tone0, amp_bus.amp_tone0);
                check_field("amp_tone1", want.amp_tone1, amp_bus.amp_tone1);
                check_field("amp_tone2", want.amp_tone2, amp_bus.amp_tone2);
                check_field("amp_noise", want.amp_noise, amp_bus.amp_noise);
                checked_count++;
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (amp_bus.valid && amp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("psg_tone_noise_generator_top verification failed");
        $finish;
    end

    initial begin : stimulus
        int n;
        int phase;
        logic [TAPS_W-1:0] taps_plan [N_PHASES];
        i_rst_n <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.func <= FUNC_WRITE;
        in_bus.write_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sound_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the tap register
        taps_access(1'b0, '0);

        for (n = 0; n < N_DIRECTED; n++)
            send_item(directed_rows[n].func, directed_rows[n].data,
                      directed_rows[n].has_amps, directed_rows[n].amps);

        // random traffic under several tap settings, extremes included
        taps_plan = '{TAPS_RESET, 15'h7FFF, 15'h0000, 15'($urandom), 15'h0001,
                      15'($urandom)};
        for (phase = 0; phase < N_PHASES; phase++) begin
            if (phase > 0) taps_access(1'b1, taps_plan[phase]);
            no_idle = (phase == 3);
            if (phase == 1) hold_off_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 3) != 0)
                    send_item(FUNC_TICK, 8'($urandom), 1'b0, '0);
                else
                    send_item(FUNC_WRITE, pick_write_byte(), 1'b0, '0);
            end
            settle();
        end

        $display("sent %0d ticks and %0d bus writes over %0d noise tap settings",
                 tick_count, write_count, N_PHASES);
        $display("compared %0d amplitude sets, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0)
            $display("psg_tone_noise_generator_top verification clean");
        else
            $display("psg_tone_noise_generator_top verification failed");
        $finish;
    end

endmodule

/* psg_tone_noise_generator_top.f */
sv/psg_pkg.sv
sv/psg_in_if.sv
sv/psg_out_if.sv
sv/psg_regs.sv
sv/psg_gen.sv
sv/psg_noise.sv
sv/psg_tone_noise_generator_top.sv
tb/psg_tone_noise_generator_top_tb.sv
